[hw/rtl/sdp_pkg.sv]
// Shared types and constants of the sample deadline pacer.
package sdp_pkg;

  // Field widths.
  localparam int unsigned TsW     = 32;
  localparam int unsigned CntW    = 13;
  localparam int unsigned CfgW    = 20;
  localparam int unsigned ThrW    = 12;
  localparam int unsigned AdcBits = 12;
  localparam int unsigned CfgIdxW = 3;

  // Longest capture the counters are meant to track.
  localparam int unsigned MaxSamples = 4096;

  // Request opcodes.
  typedef enum logic {
    OP_BEGIN  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_BEGUN    = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_COMPLETE = 2'd2,
    ST_REJECTED = 2'd3
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_INTERVAL      = 3'd0,
    CFG_INTERVAL_REMAINDER = 3'd1,
    CFG_SAMPLE_RATE_HZ     = 3'd2,
    CFG_SAMPLE_COUNT       = 3'd3,
    CFG_CLIP_LOW           = 3'd4,
    CFG_CLIP_HIGH          = 3'd5
  } cfg_idx_e;

  // Configuration seen by the core.
  typedef struct packed {
    logic [CfgW-1:0] base_interval;
    logic [CfgW-1:0] interval_remainder;
    logic [CfgW-1:0] sample_rate_hz;
    logic [CntW-1:0] sample_count;
    logic [ThrW-1:0] clip_low_threshold;
    logic [ThrW-1:0] clip_high_threshold;
  } cfg_t;

  // One registered request.
  typedef struct packed {
    op_e                opcode;
    logic [TsW-1:0]     timestamp;
    logic [AdcBits-1:0] adc_sample;
  } item_t;

  // One result.
  typedef struct packed {
    logic [TsW-1:0]     next_deadline;
    logic [TsW-1:0]     lateness;
    logic               missed_flag;
    logic               clipped_flag;
    logic [TsW-1:0]     max_lateness;
    logic [CntW-1:0]    missed_count;
    logic [CntW-1:0]    clipped_count;
    logic [CntW-1:0]    sample_index;
    logic [AdcBits-1:0] sample_value;
    logic [TsW-1:0]     span;
    status_e            status;
  } res_t;

endpackage

[hw/rtl/sdp_cfg_regs.sv]
// Configuration register file of the sample deadline pacer.
module sdp_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [sdp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sdp_pkg::CfgW-1:0]     cfg_data_i,
  output sdp_pkg::cfg_t                cfg_o
);

  sdp_pkg::cfg_t cfg_q;

  // Registers take the low bits of the write data; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_interval       <= sdp_pkg::CfgW'(25);
      cfg_q.interval_remainder  <= '0;
      cfg_q.sample_rate_hz      <= sdp_pkg::CfgW'(40000);
      cfg_q.sample_count        <= sdp_pkg::CntW'(1024);
      cfg_q.clip_low_threshold  <= sdp_pkg::ThrW'(50);
      cfg_q.clip_high_threshold <= sdp_pkg::ThrW'(4045);
    end else if (cfg_valid_i) begin
      case (sdp_pkg::cfg_idx_e'(cfg_index_i))
        sdp_pkg::CFG_BASE_INTERVAL: begin
          cfg_q.base_interval <= cfg_data_i;
        end
        sdp_pkg::CFG_INTERVAL_REMAINDER: begin
          cfg_q.interval_remainder <= cfg_data_i;
        end
        sdp_pkg::CFG_SAMPLE_RATE_HZ: begin
          cfg_q.sample_rate_hz <= cfg_data_i;
        end
        sdp_pkg::CFG_SAMPLE_COUNT: begin
          cfg_q.sample_count <= cfg_data_i[sdp_pkg::CntW-1:0];
        end
        sdp_pkg::CFG_CLIP_LOW: begin
          cfg_q.clip_low_threshold <= cfg_data_i[sdp_pkg::ThrW-1:0];
        end
        sdp_pkg::CFG_CLIP_HIGH: begin
          cfg_q.clip_high_threshold <= cfg_data_i[sdp_pkg::ThrW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/sdp_core.sv]
// Capture state and the combinational update that turns one request into a result.
module sdp_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sdp_pkg::cfg_t  cfg_i,
  input  sdp_pkg::item_t item_i,
  input  logic           fire_i,
  output sdp_pkg::res_t  res_o
);

  localparam int unsigned TsW  = sdp_pkg::TsW;
  localparam int unsigned CntW = sdp_pkg::CntW;
  localparam int unsigned CfgW = sdp_pkg::CfgW;

  // Capture state.
  logic [TsW-1:0]  deadline_q, deadline_d;
  logic [CfgW-1:0] frac_q, frac_d;
  logic [CntW-1:0] accepted_q, accepted_d;
  logic            open_q, open_d;
  logic [TsW-1:0]  first_q, first_d;
  logic [TsW-1:0]  worst_q, worst_d;
  logic [CntW-1:0] misses_q, misses_d;
  logic [CntW-1:0] clips_q, clips_d;

  // Per-sample intermediate values.
  logic [TsW-1:0]  late;
  logic            missed;
  logic            clipped;
  logic [TsW-1:0]  base_dl;
  logic [CfgW-1:0] base_frac;
  logic [CntW-1:0] cnt_next;
  logic [CntW-1:0] limit;
  logic            complete;
  logic [CfgW:0]   acc_sum;
  logic [CfgW:0]   acc_wrap;
  logic            carry;
  logic [TsW-1:0]  step;
  logic [TsW-1:0]  first_new;

  // Capture length is bounded by the longest capture supported.
  assign limit = (32'(cfg_i.sample_count) < 32'(sdp_pkg::MaxSamples)) ?
                 cfg_i.sample_count : CntW'(sdp_pkg::MaxSamples);

  // Lateness, miss detection and resynchronized deadline base.
  assign late      = item_i.timestamp - deadline_q;
  assign missed    = late >= TsW'(cfg_i.base_interval);
  assign base_dl   = missed ? item_i.timestamp : deadline_q;
  assign base_frac = missed ? '0 : frac_q;

  // Clipping margins.
  assign clipped = (12'(item_i.adc_sample) <= cfg_i.clip_low_threshold) ||
                   (12'(item_i.adc_sample) >= cfg_i.clip_high_threshold);

  // Sample count and end of capture.
  assign cnt_next  = accepted_q + CntW'(1);
  assign complete  = (cnt_next >= limit) || (cnt_next == '0);
  assign first_new = (accepted_q == '0) ? item_i.timestamp : first_q;

  // Fractional accumulator: at most one carry per sample.
  assign acc_sum  = {1'b0, base_frac} + {1'b0, cfg_i.interval_remainder};
  assign carry    = acc_sum >= {1'b0, cfg_i.sample_rate_hz};
  assign acc_wrap = carry ? (acc_sum - {1'b0, cfg_i.sample_rate_hz}) : acc_sum;
  assign step     = TsW'(cfg_i.base_interval) + TsW'(carry);

  // Next state and result for the request at the head of the pipe.
  always_comb begin
    deadline_d = deadline_q;
    frac_d     = frac_q;
    accepted_d = accepted_q;
    open_d     = open_q;
    first_d    = first_q;
    worst_d    = worst_q;
    misses_d   = misses_q;
    clips_d    = clips_q;
    res_o      = '0;

    if (item_i.opcode == sdp_pkg::OP_BEGIN) begin
      // Open a capture and clear its statistics.
      open_d     = 1'b1;
      deadline_d = item_i.timestamp;
      frac_d     = '0;
      accepted_d = '0;
      first_d    = '0;
      worst_d    = '0;
      misses_d   = '0;
      clips_d    = '0;
      res_o.next_deadline = item_i.timestamp;
      res_o.status        = sdp_pkg::ST_BEGUN;
    end else if (!open_q) begin
      // No capture open: echo the state, change nothing.
      res_o.next_deadline = deadline_q;
      res_o.max_lateness  = worst_q;
      res_o.missed_count  = misses_q;
      res_o.clipped_count = clips_q;
      res_o.sample_index  = accepted_q;
      res_o.status        = sdp_pkg::ST_REJECTED;
    end else begin
      worst_d    = (late > worst_q) ? late : worst_q;
      misses_d   = missed ? misses_q + CntW'(1) : misses_q;
      clips_d    = clipped ? clips_q + CntW'(1) : clips_q;
      first_d    = first_new;
      accepted_d = cnt_next;
      if (complete) begin
        open_d     = 1'b0;
        deadline_d = base_dl;
        frac_d     = base_frac;
        res_o.span   = item_i.timestamp - first_new;
        res_o.status = sdp_pkg::ST_COMPLETE;
      end else begin
        deadline_d   = base_dl + step;
        frac_d       = acc_wrap[CfgW-1:0];
        res_o.status = sdp_pkg::ST_ACCEPTED;
      end
      res_o.next_deadline = deadline_d;
      res_o.lateness      = late;
      res_o.missed_flag   = missed;
      res_o.clipped_flag  = clipped;
      res_o.max_lateness  = worst_d;
      res_o.missed_count  = misses_d;
      res_o.clipped_count = clips_d;
      res_o.sample_index  = cnt_next;
      res_o.sample_value  = item_i.adc_sample;
    end
  end

  // State registers advance once per request passed on to the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= '0;
      frac_q     <= '0;
      accepted_q <= '0;
      open_q     <= 1'b0;
      first_q    <= '0;
      worst_q    <= '0;
      misses_q   <= '0;
      clips_q    <= '0;
    end else if (fire_i) begin
      deadline_q <= deadline_d;
      frac_q     <= frac_d;
      accepted_q <= accepted_d;
      open_q     <= open_d;
      first_q    <= first_d;
      worst_q    <= worst_d;
      misses_q   <= misses_d;
      clips_q    <= clips_d;
    end
  end

endmodule

[hw/rtl/sample_deadline_pacer.sv]
// Top level of the sample deadline pacer: request register, core and result register.
//
// The pacer takes one request per clock cycle while the result side does not stall.
// A request accepted at a clock edge sits in the request register, then moves through
// the core into the result register, from which its result is offered. The rate is
// set by the combinational capture state update in the core, which sits between the
// request register and the result register. Both stages advance while the result
// register is empty or being taken, so a stalled result holds the pipe without
// losing anything. There is no clearing pass after reset. Configuration writes are
// always taken.
module sample_deadline_pacer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sdp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sdp_pkg::CfgW-1:0]          cfg_data_i,
  // Request channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [sdp_pkg::TsW-1:0]           timestamp_i,
  input  logic [sdp_pkg::AdcBits-1:0]       adc_sample_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sdp_pkg::TsW-1:0]           next_deadline_o,
  output logic [sdp_pkg::TsW-1:0]           lateness_o,
  output logic                              missed_flag_o,
  output logic                              clipped_flag_o,
  output logic [sdp_pkg::TsW-1:0]           max_lateness_o,
  output logic [sdp_pkg::CntW-1:0]          missed_count_o,
  output logic [sdp_pkg::CntW-1:0]          clipped_count_o,
  output logic [sdp_pkg::CntW-1:0]          sample_index_o,
  output logic [sdp_pkg::AdcBits-1:0]       sample_value_o,
  output logic [sdp_pkg::TsW-1:0]           span_o,
  output logic [1:0]                        status_o
);

  sdp_pkg::cfg_t  cfg;
  sdp_pkg::item_t item_q;
  sdp_pkg::res_t  res_d, res_q;
  logic           item_valid_q;
  logic           out_valid_q;
  logic           advance;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  sdp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Pipe control: the head request moves on when the result register frees up.
  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  // Request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.opcode     <= sdp_pkg::op_e'(opcode_i);
      item_q.timestamp  <= timestamp_i;
      item_q.adc_sample <= adc_sample_i;
    end
  end

  // Capture state and result computation.
  sdp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item_q),
    .fire_i (advance),
    .res_o  (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign next_deadline_o = res_q.next_deadline;
  assign lateness_o      = res_q.lateness;
  assign missed_flag_o   = res_q.missed_flag;
  assign clipped_flag_o  = res_q.clipped_flag;
  assign max_lateness_o  = res_q.max_lateness;
  assign missed_count_o  = res_q.missed_count;
  assign clipped_count_o = res_q.clipped_count;
  assign sample_index_o  = res_q.sample_index;
  assign sample_value_o  = res_q.sample_value;
  assign span_o          = res_q.span;
  assign status_o        = res_q.status;

endmodule

[hw/rtl/sdp_checker.sv]
// Port-level checks of the sample deadline pacer and their binding to the top level.
module sdp_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_o,
  input  logic [sdp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sdp_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [sdp_pkg::TsW-1:0]           timestamp_i,
  input  logic [sdp_pkg::AdcBits-1:0]       adc_sample_i,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  logic [sdp_pkg::TsW-1:0]           next_deadline_o,
  input  logic [sdp_pkg::TsW-1:0]           lateness_o,
  input  logic                              missed_flag_o,
  input  logic                              clipped_flag_o,
  input  logic [sdp_pkg::TsW-1:0]           max_lateness_o,
  input  logic [sdp_pkg::CntW-1:0]          missed_count_o,
  input  logic [sdp_pkg::CntW-1:0]          clipped_count_o,
  input  logic [sdp_pkg::CntW-1:0]          sample_index_o,
  input  logic [sdp_pkg::AdcBits-1:0]       sample_value_o,
  input  logic [sdp_pkg::TsW-1:0]           span_o,
  input  logic [1:0]                        status_o
);

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(next_deadline_o) && $stable(status_o) &&
      $stable(sample_index_o) && $stable(span_o))
    else $error("stalled result changed");

  // A begin result carries cleared statistics.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == sdp_pkg::ST_BEGUN |->
      max_lateness_o == '0 && missed_count_o == '0 &&
      clipped_count_o == '0 && sample_index_o == '0 && span_o == '0)
    else $error("begin result with nonzero statistics");

  // Span is only reported when a capture completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != sdp_pkg::ST_COMPLETE |-> span_o == '0)
    else $error("span outside capture completion");

  // A rejected sample carries no per-sample measurement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == sdp_pkg::ST_REJECTED |->
      lateness_o == '0 && !missed_flag_o && !clipped_flag_o &&
      sample_value_o == '0)
    else $error("rejected sample with measurement");

  // An accepted sample inside an open capture has a nonzero index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == sdp_pkg::ST_ACCEPTED |-> sample_index_o != '0)
    else $error("accepted sample with zero index");

endmodule

bind sample_deadline_pacer sdp_checker u_sdp_checker (.*);

[sim/tb_top.sv]
// Self-checking testbench for the sample deadline pacer: capture pacing, statistics and span.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sdp_pkg::*;

  localparam int unsigned RandomItems = 720;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned HoldCycles  = 100;

  // Flavors of a randomly chosen register set.
  typedef enum int unsigned {
    FLAVOR_TYPICAL,
    FLAVOR_WIDE,
    FLAVOR_EXTREME
  } cfg_flavor_e;

  // Tracks the capture state, predicts each result and checks what comes out.
  class deadline_tracker;
    logic [CfgW-1:0] base_interval, interval_remainder, sample_rate_hz;
    logic [CntW-1:0] sample_count;
    logic [ThrW-1:0] clip_low, clip_high;
    logic [TsW-1:0]  deadline, first_time, last_time, worst_lateness;
    logic [CfgW-1:0] fraction;
    logic [CntW-1:0] accepted, misses, clips;
    logic            capture_open;
    res_t            pending[$];
    int unsigned     errors;

    function new();
      base_interval      = 25;
      interval_remainder = 0;
      sample_rate_hz     = 40000;
      sample_count       = 1024;
      clip_low           = 50;
      clip_high          = 4045;
      deadline           = '0;
      capture_open       = 1'b0;
      errors             = 0;
      clear_capture();
    endfunction

    function void clear_capture();
      fraction       = '0;
      accepted       = '0;
      first_time     = '0;
      last_time      = '0;
      worst_lateness = '0;
      misses         = '0;
      clips          = '0;
    endfunction

    // Mirror a register write; narrow registers keep their low bits.
    function void set_register(cfg_idx_e idx, logic [CfgW-1:0] data);
      case (idx)
        CFG_BASE_INTERVAL:      base_interval = data;
        CFG_INTERVAL_REMAINDER: interval_remainder = data;
        CFG_SAMPLE_RATE_HZ:     sample_rate_hz = data;
        CFG_SAMPLE_COUNT:       sample_count = data[CntW-1:0];
        CFG_CLIP_LOW:           clip_low = data[ThrW-1:0];
        CFG_CLIP_HIGH:          clip_high = data[ThrW-1:0];
        default: ;
      endcase
    endfunction

    // Work out the result of one accepted request and queue it.
    function void accept_request(op_e op, logic [TsW-1:0] ts, logic [AdcBits-1:0] smp);
      res_t            r;
      logic [TsW-1:0]  late_v, step_v, acc_v;
      logic [CntW-1:0] cap;
      r = '0;
      if (op == OP_BEGIN) begin
        capture_open = 1'b1;
        deadline     = ts;
        clear_capture();
        r.next_deadline = deadline;
        r.status        = ST_BEGUN;
      end else if (!capture_open) begin
        // A sample with no capture open only echoes the statistics.
        r.next_deadline = deadline;
        r.max_lateness  = worst_lateness;
        r.missed_count  = misses;
        r.clipped_count = clips;
        r.sample_index  = accepted;
        r.status        = ST_REJECTED;
      end else begin
        late_v = ts - deadline;
        if (late_v > worst_lateness) worst_lateness = late_v;
        // A late or early sample resynchronizes the deadline.
        if (late_v >= base_interval) begin
          r.missed_flag = 1'b1;
          misses        = misses + 1'b1;
          deadline      = ts;
          fraction      = '0;
        end
        r.clipped_flag = (smp <= clip_low) || (smp >= clip_high);
        if (r.clipped_flag) clips = clips + 1'b1;
        if (accepted == '0) first_time = ts;
        last_time = ts;
        accepted  = accepted + 1'b1;
        cap = (sample_count < MaxSamples) ? sample_count : CntW'(MaxSamples);
        if (accepted >= cap || accepted == '0) begin
          r.span       = last_time - first_time;
          capture_open = 1'b0;
          r.status     = ST_COMPLETE;
        end else begin
          // Whole interval plus at most one carry from the fraction.
          step_v = base_interval;
          acc_v  = fraction + interval_remainder;
          if (acc_v >= sample_rate_hz) begin
            step_v = step_v + 1;
            acc_v  = acc_v - sample_rate_hz;
          end
          fraction = acc_v[CfgW-1:0];
          deadline = deadline + step_v;
          r.status = ST_ACCEPTED;
        end
        r.lateness      = late_v;
        r.next_deadline = deadline;
        r.max_lateness  = worst_lateness;
        r.missed_count  = misses;
        r.clipped_count = clips;
        r.sample_index  = accepted;
        r.sample_value  = smp;
      end
      pending.push_back(r);
    endfunction

    function void check_field(string name, logic [TsW-1:0] want, logic [TsW-1:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
    endfunction

    // Compare one delivered result with the oldest prediction.
    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        errors++;
        $error("result delivered with no request outstanding");
        return;
      end
      want = pending.pop_front();
      check_field("next_deadline", want.next_deadline, got.next_deadline);
      check_field("lateness", want.lateness, got.lateness);
      check_field("missed_flag", want.missed_flag, got.missed_flag);
      check_field("clipped_flag", want.clipped_flag, got.clipped_flag);
      check_field("max_lateness", want.max_lateness, got.max_lateness);
      check_field("missed_count", want.missed_count, got.missed_count);
      check_field("clipped_count", want.clipped_count, got.clipped_count);
      check_field("sample_index", want.sample_index, got.sample_index);
      check_field("sample_value", want.sample_value, got.sample_value);
      check_field("span", want.span, got.span);
      check_field("status", want.status, got.status);
    endfunction
  endclass

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i  = '0;
  logic [CfgW-1:0]      cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic                 opcode_i     = 1'b0;
  logic [TsW-1:0]       timestamp_i  = '0;
  logic [AdcBits-1:0]   adc_sample_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [TsW-1:0]       next_deadline_o, lateness_o, max_lateness_o, span_o;
  logic                 missed_flag_o, clipped_flag_o;
  logic [CntW-1:0]      missed_count_o, clipped_count_o, sample_index_o;
  logic [AdcBits-1:0]   sample_value_o;
  logic [1:0]           status_o;
  res_t                 seen;

  deadline_tracker tracker = new();
  bit              calm = 1'b0;
  bit              hold_results = 1'b0;
  int unsigned     items_sent = 0;
  int unsigned     quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  sample_deadline_pacer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .timestamp_i     (timestamp_i),
    .adc_sample_i    (adc_sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .next_deadline_o (next_deadline_o),
    .lateness_o      (lateness_o),
    .missed_flag_o   (missed_flag_o),
    .clipped_flag_o  (clipped_flag_o),
    .max_lateness_o  (max_lateness_o),
    .missed_count_o  (missed_count_o),
    .clipped_count_o (clipped_count_o),
    .sample_index_o  (sample_index_o),
    .sample_value_o  (sample_value_o),
    .span_o          (span_o),
    .status_o        (status_o)
  );

  assign seen = {next_deadline_o, lateness_o, missed_flag_o, clipped_flag_o, max_lateness_o,
                 missed_count_o, clipped_count_o, sample_index_o, sample_value_o, span_o,
                 status_e'(status_o)};

  // Results are checked at the edge that takes them.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_result(seen);
  end

  // End the run if nothing moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QuietLimit) begin
        $display("[sample_deadline_pacer] ERROR");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, plus one long hold when asked.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_results) begin
        hold_results = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  // One register write; valid stays up for a following write.
  task automatic write_register(cfg_idx_e idx, logic [CfgW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.set_register(idx, data);
    @(negedge clk_i);
  endtask

  task automatic write_all(logic [CfgW-1:0] base_v, logic [CfgW-1:0] rem_v,
                           logic [CfgW-1:0] rate_v, logic [CfgW-1:0] cnt_v,
                           logic [CfgW-1:0] lo_v, logic [CfgW-1:0] hi_v);
    write_register(CFG_BASE_INTERVAL, base_v);
    write_register(CFG_INTERVAL_REMAINDER, rem_v);
    write_register(CFG_SAMPLE_RATE_HZ, rate_v);
    write_register(CFG_SAMPLE_COUNT, cnt_v);
    write_register(CFG_CLIP_LOW, lo_v);
    write_register(CFG_CLIP_HIGH, hi_v);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one request, with a random gap in front of it, and wait for it to be taken.
  task automatic send(op_e op, logic [TsW-1:0] ts, logic [AdcBits-1:0] smp);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    timestamp_i  <= ts;
    adc_sample_i <= smp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.accept_request(op, ts, smp);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and let every outstanding result drain.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Sample time relative to the predicted deadline: on time, at the miss edge,
  // late, early (which wraps to a huge lateness) or anywhere.
  function automatic logic [TsW-1:0] pick_sample_time();
    logic [TsW-1:0] dl, base;
    int unsigned    pick;
    dl   = tracker.deadline;
    base = tracker.base_interval;
    pick = $urandom_range(0, 99);
    if (pick < 55) return (base == 0) ? dl : dl + $urandom_range(0, base - 1);
    if (pick < 65) return dl + base - 1;
    if (pick < 75) return dl + base;
    if (pick < 85) return dl + base + $urandom_range(1, 5000);
    if (pick < 95) return dl - $urandom_range(1, 5000);
    return $urandom;
  endfunction

  // Converter value, often right on or next to a clipping threshold.
  function automatic logic [AdcBits-1:0] pick_adc_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return tracker.clip_low;
    if (pick < 15) return tracker.clip_low + 1'b1;
    if (pick < 25) return tracker.clip_high;
    if (pick < 30) return tracker.clip_high - 1'b1;
    if (pick < 35) return '0;
    if (pick < 40) return '1;
    return AdcBits'($urandom);
  endfunction

  task automatic send_sample();
    send(OP_SAMPLE, pick_sample_time(), pick_adc_value());
  endtask

  // Pick a register set; the long flavor asks for more samples than a capture can hold.
  task automatic configure(cfg_flavor_e flavor, bit long_capture);
    logic [CfgW-1:0] base_v, rem_v, rate_v, cnt_v, lo_v, hi_v;
    case (flavor)
      FLAVOR_TYPICAL: begin
        base_v = CfgW'($urandom_range(1, 200));
        rate_v = CfgW'($urandom_range(1, 100000));
        rem_v  = CfgW'($urandom_range(0, rate_v - 1));
        cnt_v  = CfgW'($urandom_range(1, 16));
        lo_v   = CfgW'($urandom_range(0, 200));
        hi_v   = CfgW'($urandom_range(3895, 4095));
      end
      FLAVOR_WIDE: begin
        // Upper data bits are set at random to show that narrow registers drop them.
        base_v = CfgW'($urandom);
        rem_v  = CfgW'($urandom);
        rate_v = CfgW'($urandom);
        cnt_v  = {7'($urandom), 13'($urandom_range(0, 12))};
        lo_v   = CfgW'($urandom);
        hi_v   = CfgW'($urandom);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: base_v = 1;
          1: base_v = 1000000;
          2: base_v = 0;
          default: base_v = '1;
        endcase
        case ($urandom_range(0, 2))
          0: rem_v = 0;
          1: rem_v = 999999;
          default: rem_v = '1;
        endcase
        case ($urandom_range(0, 3))
          0: rate_v = 1;
          1: rate_v = 1000000;
          2: rate_v = 0;
          default: rate_v = '1;
        endcase
        cnt_v = CfgW'($urandom_range(0, 2));
        lo_v  = $urandom_range(0, 1) ? CfgW'(4095) : CfgW'(0);
        hi_v  = $urandom_range(0, 1) ? CfgW'(4095) : CfgW'(0);
      end
    endcase
    if (long_capture) cnt_v = '1;
    write_all(base_v, rem_v, rate_v, cnt_v, lo_v, hi_v);
  endtask

  // One capture: mostly complete, sometimes cut short, overrun or replaced by noise.
  task automatic run_capture();
    int unsigned     shape, n;
    logic [CntW-1:0] cnt;
    cnt   = tracker.sample_count;
    n     = (cnt == 0) ? 1 : ((cnt > MaxSamples) ? MaxSamples : cnt);
    shape = $urandom_range(0, 99);
    if (shape < 10) repeat ($urandom_range(1, 2)) send_sample();
    send(OP_BEGIN, $urandom, AdcBits'($urandom));
    if (shape < 75) begin
      repeat (n) send_sample();
      if (shape >= 55) send_sample();
    end else if (shape < 90) begin
      repeat ($urandom_range(0, n - 1)) send_sample();
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send($urandom_range(0, 1) ? OP_SAMPLE : OP_BEGIN, $urandom, AdcBits'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned random_start;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset registers: rejection before any capture, wrap of the deadline,
    // both clipping edges, the miss edge and an early sample.
    send(OP_SAMPLE, 32'd123, 12'd7);
    send(OP_BEGIN, 32'hFFFF_FFF0, 12'hFFF);
    send(OP_SAMPLE, tracker.deadline + 3, 12'd0);
    send(OP_SAMPLE, tracker.deadline, 12'hFFF);
    send(OP_SAMPLE, tracker.deadline + 24, 12'd50);
    send(OP_SAMPLE, tracker.deadline + 25, 12'd51);
    send(OP_SAMPLE, tracker.deadline - 1, 12'd4044);
    send(OP_SAMPLE, tracker.deadline + 1, 12'd4045);
    send(OP_SAMPLE, 32'hFFFF_FFFF, 12'h800);
    wait_idle();

    // Remainder above the rate: a carry on every sample; short capture with
    // completion, then a sample past the end.
    write_all(20'd1, 20'd5, 20'd3, 20'd3, 20'd0, 20'd4095);
    send(OP_BEGIN, 32'd0, 12'd0);
    repeat (3) send(OP_SAMPLE, tracker.deadline, 12'h555);
    send(OP_SAMPLE, tracker.deadline, 12'hAAA);
    wait_idle();

    // A sample count of zero closes the capture after one sample.
    write_all(20'd1, 20'd5, 20'd3, 20'd0, 20'd0, 20'd4095);
    send(OP_BEGIN, 32'h8000_0000, 12'd0);
    send(OP_SAMPLE, tracker.deadline, 12'd1);
    send(OP_SAMPLE, tracker.deadline, 12'd2);
    wait_idle();

    // Zero interval and rate: every sample misses, every value clips.
    write_all(20'd0, 20'hFFFFF, 20'd0, 20'd2, 20'd4095, 20'd0);
    send(OP_BEGIN, 32'h1234_5678, 12'd0);
    send(OP_SAMPLE, tracker.deadline, 12'h7FF);
    send(OP_SAMPLE, tracker.deadline + 9, 12'h800);
    wait_idle();

    // Widest interval and rate; oversized sample count is held to the maximum.
    write_all(20'hFFFFF, 20'hFFFFE, 20'hFFFFF, 20'hFFFFF, 20'd0, 20'd4095);
    send(OP_BEGIN, 32'h0000_0001, 12'd0);
    repeat (3) send(OP_SAMPLE, tracker.deadline + 32'h000F_FFFE, 12'd100);

    // Random phases, each with a fresh register set.
    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RandomItems) begin
      wait_idle();
      calm = (phase == 4 || phase == 5);
      case (phase % 3)
        0: configure(FLAVOR_TYPICAL, 1'b0);
        1: configure(FLAVOR_WIDE, 1'b0);
        default: configure(FLAVOR_EXTREME, 1'b0);
      endcase
      // Hold the result side once so the pipe fills and the request side stalls.
      if (phase == 1) hold_results = 1'b1;
      repeat ($urandom_range(3, 6)) run_capture();
      phase++;
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("[sample_deadline_pacer] OK");
    end else begin
      $display("[sample_deadline_pacer] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/sdp_pkg.sv
hw/rtl/sdp_cfg_regs.sv
hw/rtl/sdp_core.sv
hw/rtl/sample_deadline_pacer.sv
hw/rtl/sdp_checker.sv
sim/tb_top.sv
